[sv/ivt_pkg.sv]
// ----------------------------------------------------------------------------
// ivt_pkg
// Shared types and constants for the interrupt vector table.
// ----------------------------------------------------------------------------
package ivt_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 16;

    // Field widths
    localparam int SRC_W   = 8;
    localparam int ADDR_W  = 32;
    localparam int ENTRY_W = SRC_W + ADDR_W;
    localparam int COUNT_W = 5;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_REGISTER   = 2'd0,
        KIND_UNREGISTER = 2'd1,
        KIND_LOOKUP     = 2'd2,
        KIND_UNUSED     = 2'd3
    } t_kind;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_RESP  = 4'b1000
    } t_state;

    // Result handed from sequencer to output stage
    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [ADDR_W-1:0] addr;
    } t_resp;

endpackage

[sv/ivt_ram.sv]
// ----------------------------------------------------------------------------
// ivt_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ivt_ram #(
    parameter  int WIDTH = 40,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/ivt_ctrl.sv]
// ----------------------------------------------------------------------------
// ivt_ctrl
// Request sequencer: appends, scans for first match, shifts entries down.
// ----------------------------------------------------------------------------
module ivt_ctrl #(
    parameter  int TABLE_ENTRIES = ivt_pkg::TABLE_ENTRIES_DEF,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_kind,
    input  logic [ivt_pkg::SRC_W-1:0]   i_source,
    input  logic [ivt_pkg::ADDR_W-1:0]  i_handler_address,
    output logic                        o_wr_en,
    output logic [IW-1:0]               o_wr_addr,
    output logic [ivt_pkg::ENTRY_W-1:0] o_wr_data,
    output logic [IW-1:0]               o_rd_addr,
    input  logic [ivt_pkg::ENTRY_W-1:0] i_rd_data,
    input  logic                        i_out_free,
    output ivt_pkg::t_resp              o_resp,
    output logic [CW-1:0]               o_count
);
    import ivt_pkg::*;

    t_state             r_state, n_state;
    logic [IW-1:0]      r_chk, n_chk;
    logic [CW-1:0]      r_count, n_count;
    t_kind              r_kind, n_kind;
    logic [SRC_W-1:0]   r_src, n_src;
    logic               r_ok, n_ok;
    logic [ADDR_W-1:0]  r_addr, n_addr;

    logic [CW-1:0]      chk_p1;
    logic [CW-1:0]      chk_p2;
    logic               match;

    assign chk_p1 = CW'(r_chk) + CW'(1);
    assign chk_p2 = chk_p1 + CW'(1);
    assign match  = (i_rd_data[ENTRY_W-1 -: SRC_W] == r_src);

    // Next-state and memory access logic
    always_comb begin
        n_state   = r_state;
        n_chk     = r_chk;
        n_count   = r_count;
        n_kind    = r_kind;
        n_src     = r_src;
        n_ok      = r_ok;
        n_addr    = r_addr;
        o_wr_en   = 1'b0;
        o_wr_addr = r_chk;
        o_wr_data = i_rd_data;
        o_rd_addr = chk_p1[IW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_kind = t_kind'(i_kind);
                    n_src  = i_source;
                    n_ok   = 1'b0;
                    n_addr = '0;
                    n_chk  = '0;
                    case (t_kind'(i_kind))
                        KIND_REGISTER: begin
                            if (r_count < CW'(TABLE_ENTRIES)) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_count[IW-1:0];
                                o_wr_data = {i_source, i_handler_address};
                                n_count   = r_count + CW'(1);
                                n_ok      = 1'b1;
                            end
                            n_state = ST_RESP;
                        end
                        KIND_UNREGISTER, KIND_LOOKUP: begin
                            o_rd_addr = '0;
                            n_state   = (r_count == '0) ? ST_RESP : ST_SCAN;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Data for entry r_chk arrives; read of r_chk+1 goes out
                if (match) begin
                    n_ok = 1'b1;
                    if (r_kind == KIND_LOOKUP) begin
                        n_addr  = i_rd_data[ADDR_W-1:0];
                        n_state = ST_RESP;
                    end else if (chk_p1 == r_count) begin
                        n_count = r_count - CW'(1);
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_SHIFT;
                    end
                end else if (chk_p1 == r_count) begin
                    n_state = ST_RESP;
                end else begin
                    n_chk = r_chk + IW'(1);
                end
            end
            ST_SHIFT: begin
                // Entry r_chk+1 arrives and moves down to r_chk
                o_rd_addr = chk_p2[IW-1:0];
                o_wr_en   = 1'b1;
                if (chk_p2 == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = ST_RESP;
                end else begin
                    n_chk = r_chk + IW'(1);
                end
            end
            ST_RESP: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_chk  <= n_chk;
        r_kind <= n_kind;
        r_src  <= n_src;
        r_ok   <= n_ok;
        r_addr <= n_addr;
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_resp.valid = (r_state == ST_RESP);
    assign o_resp.ok    = r_ok;
    assign o_resp.addr  = r_addr;
    assign o_count      = r_count;

endmodule

[sv/interrupt_vector_table_top.sv]
// Register and unused kind go straight to the response state after acceptance;
// lookup and unregister walk the table one entry per cycle through the RAM
// read port until a match or the last entry, and an unregister then shifts
// any later entries down one place. Items are taken one at a time: a new
// request stalls until the last result enters the output register. Reset empties the table at once.
// ----------------------------------------------------------------------------
// interrupt_vector_table_top
// Packed interrupt vector table with register, unregister and lookup.
// ----------------------------------------------------------------------------
module interrupt_vector_table_top #(
    parameter int TABLE_ENTRIES = ivt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_kind,
    input  logic [ivt_pkg::SRC_W-1:0]     i_source,
    input  logic [ivt_pkg::ADDR_W-1:0]    i_handler_address,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_ok,
    output logic [ivt_pkg::ADDR_W-1:0]    o_found_address,
    output logic [ivt_pkg::COUNT_W-1:0]   o_entry_count
);
    import ivt_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [IW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    t_resp              resp;
    logic [CW-1:0]      count;
    logic [31:0]        count_ext;
    logic               out_free;

    logic               r_out_valid;
    logic               r_ok;
    logic [ADDR_W-1:0]  r_found;
    logic [COUNT_W-1:0] r_cnt;

    // Vector storage
    ivt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Request sequencer
    ivt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_source          (i_source),
        .i_handler_address (i_handler_address),
        .o_wr_en           (wr_en),
        .o_wr_addr         (wr_addr),
        .o_wr_data         (wr_data),
        .o_rd_addr         (rd_addr),
        .i_rd_data         (rd_data),
        .i_out_free        (out_free),
        .o_resp            (resp),
        .o_count           (count)
    );

    assign count_ext = 32'(count);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (resp.valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload, loaded with each new item
    always_ff @(posedge i_clk) begin
        if (resp.valid && out_free) begin
            r_ok    <= resp.ok;
            r_found <= resp.addr;
            r_cnt   <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_ok;
    assign o_found_address = r_found;
    assign o_entry_count   = r_cnt;

endmodule

[tb/sv/tb_interrupt_vector_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interrupt_vector_table_top
// Self-checking bench for the interrupt vector table. A shadow table predicts
// every result, covering register, unregister, lookup and the unused kind,
// under directed cases, back-pressure and random traffic with random idling.
// ----------------------------------------------------------------------------
module tb_interrupt_vector_table_top;
    import ivt_pkg::*;

    localparam int ENTRIES         = TABLE_ENTRIES_DEF;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int END_TAIL        = 2 * ENTRIES + 8;
    localparam int MAX_REPORTS     = 10;
    localparam int ITEMS_PER_PHASE = 310;
    localparam int BURST_LEN       = 32;

    typedef struct packed {
        logic               ok;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
    } t_vector_result;

    // DUT ports
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_kind;
    logic [SRC_W-1:0]   i_source;
    logic [ADDR_W-1:0]  i_handler_address;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_ok;
    logic [ADDR_W-1:0]  o_found_address;
    logic [COUNT_W-1:0] o_entry_count;

    // Shadow table and expected results
    logic [SRC_W-1:0]   shadow_src [ENTRIES];
    logic [ADDR_W-1:0]  shadow_hdl [ENTRIES];
    int                 shadow_count;
    t_vector_result     pending_results[$];

    // Bench control and statistics
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int mismatches;
    int results_checked;
    int quiet_cycles;
    int kind_seen [4];
    int full_refusals;
    int unmatched;

    interrupt_vector_table_top #(
        .TABLE_ENTRIES(ENTRIES)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_source         (i_source),
        .i_handler_address(i_handler_address),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_ok             (o_ok),
        .o_found_address  (o_found_address),
        .o_entry_count    (o_entry_count)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one accepted request to the shadow table, queue its result
    function automatic void apply_request(t_kind kind, logic [SRC_W-1:0] src,
                                          logic [ADDR_W-1:0] addr);
        t_vector_result res;
        int hit;
        res = '0;
        hit = -1;
        for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_src[i] == src) hit = i;
        end
        case (kind)
            KIND_REGISTER: begin
                if (shadow_count < ENTRIES) begin
                    shadow_src[shadow_count] = src;
                    shadow_hdl[shadow_count] = addr;
                    shadow_count++;
                    res.ok = 1'b1;
                end else begin
                    full_refusals++;
                end
            end
            KIND_UNREGISTER: begin
                if (hit >= 0) begin
                    for (int j = hit; j < shadow_count - 1; j++) begin
                        shadow_src[j] = shadow_src[j+1];
                        shadow_hdl[j] = shadow_hdl[j+1];
                    end
                    shadow_count--;
                    // vacated top slot goes back to zero
                    shadow_src[shadow_count] = '0;
                    shadow_hdl[shadow_count] = '0;
                    res.ok = 1'b1;
                end else begin
                    unmatched++;
                end
            end
            KIND_LOOKUP: begin
                if (hit >= 0) begin
                    res.ok   = 1'b1;
                    res.addr = shadow_hdl[hit];
                end else begin
                    unmatched++;
                end
            end
            default: ;
        endcase
        res.count = shadow_count[COUNT_W-1:0];
        pending_results.push_back(res);
        kind_seen[kind]++;
    endfunction

    // Mostly sources already in the table or a small pool, so matches happen
    function automatic logic [SRC_W-1:0] pick_source();
        int r;
        r = $urandom_range(99);
        if (r < 50 && shadow_count > 0) return shadow_src[$urandom_range(shadow_count - 1)];
        if (r < 80) return SRC_W'($urandom_range(7));
        return SRC_W'($urandom_range(255));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return $urandom;
    endfunction

    // Offer one item after a random idle gap, hold it until accepted
    task automatic send_item(t_kind kind, logic [SRC_W-1:0] src, logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_kind            <= kind;
        i_source          <= src;
        i_handler_address <= addr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_request(kind, src, addr);
    endtask

    task automatic send_random_item(int reg_weight);
        int    r;
        t_kind kind;
        r = $urandom_range(99);
        if (r < reg_weight)  kind = KIND_REGISTER;
        else if (r < 96)     kind = $urandom_range(1) ? KIND_UNREGISTER : KIND_LOOKUP;
        else                 kind = KIND_UNUSED;
        send_item(kind, pick_source(), pick_address());
    endtask

    // Sender pauses until every queued result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Lookup, unregister and unused kind on an empty table
    task automatic test_empty_table();
        send_item(KIND_LOOKUP, 8'h00, 32'h0000_0000);
        send_item(KIND_UNREGISTER, 8'hFF, 32'hFFFF_FFFF);
        send_item(KIND_UNUSED, 8'h5A, 32'hFFFF_FFFF);
    endtask

    // Fill with field extremes and a duplicate, then overflow and send an unused kind
    task automatic test_fill_and_overflow();
        send_item(KIND_REGISTER, 8'h00, 32'h0000_0000);
        send_item(KIND_REGISTER, 8'hFF, 32'hFFFF_FFFF);
        send_item(KIND_REGISTER, 8'h55, 32'h1111_1111);
        send_item(KIND_REGISTER, 8'h55, 32'h2222_2222);
        for (int i = 4; i < ENTRIES; i++) send_item(KIND_REGISTER, SRC_W'(8'h10 + i), $urandom);
        send_item(KIND_REGISTER, 8'h77, 32'hDEAD_BEEF);
        send_item(KIND_UNUSED, 8'hAA, 32'h5555_5555);
    endtask

    // First-match on duplicates, shift on removal, removal of the top entry
    task automatic test_duplicates_and_removal();
        send_item(KIND_LOOKUP, 8'h55, 32'h0);
        send_item(KIND_UNREGISTER, 8'h55, 32'h0);
        send_item(KIND_LOOKUP, 8'h55, 32'h0);
        send_item(KIND_LOOKUP, SRC_W'(8'h10 + ENTRIES - 1), 32'h0);
        send_item(KIND_UNREGISTER, SRC_W'(8'h10 + ENTRIES - 1), 32'h0);
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        repeat (16) send_random_item(60);
        drain_results();
    endtask

    // Random traffic in bursts, each leaning at random towards filling or draining the table
    task automatic test_random_traffic(int tx_pct, int rx_pct, int n_items);
        int reg_weight;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        reg_weight  = 75;
        for (int n = 0; n < n_items; n++) begin
            if (n % BURST_LEN == 0) reg_weight = $urandom_range(1) ? 75 : 25;
            send_random_item(reg_weight);
        end
        drain_results();
    endtask

    // Result check
    always @(posedge i_clk) begin
        t_vector_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: ok=%0b addr=%h count=%0d",
                             o_ok, o_found_address, o_entry_count);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_ok !== want.ok || o_found_address !== want.addr ||
                    o_entry_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result %0d: expected ok=%0b addr=%h count=%0d, ",
                                  "got ok=%0b addr=%h count=%0d"},
                                 results_checked, want.ok, want.addr, want.count,
                                 o_ok, o_found_address, o_entry_count);
                end
            end
        end
    end

    // Receiver stall; hold-off requests take priority over random stalls
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no handshake for %0d cycles, %0d results pending",
                             quiet_cycles, pending_results.size());
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_kind            <= KIND_REGISTER;
        i_source          <= '0;
        i_handler_address <= '0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        hold_requests   = 0;
        hold_served     = 0;
        hold_left       = 0;
        mismatches      = 0;
        results_checked = 0;
        quiet_cycles    = 0;
        full_refusals   = 0;
        unmatched       = 0;
        shadow_count    = 0;
        for (int k = 0; k < 4; k++) kind_seen[k] = 0;
        for (int e = 0; e < ENTRIES; e++) begin
            shadow_src[e] = '0;
            shadow_hdl[e] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_fill_and_overflow();
        test_duplicates_and_removal();
        drain_results();
        test_backpressure();
        test_random_traffic(0, 0, ITEMS_PER_PHASE);
        test_random_traffic(82, 0, ITEMS_PER_PHASE);
        test_random_traffic(0, 82, ITEMS_PER_PHASE);
        test_random_traffic(21, 21, ITEMS_PER_PHASE);

        // let any stray result show up
        repeat (END_TAIL) @(posedge i_clk);
        mismatches += pending_results.size();

        $display({"covered %0d requests: %0d register, %0d unregister, ",
                  "%0d lookup, %0d unused kind"},
                 kind_seen[0] + kind_seen[1] + kind_seen[2] + kind_seen[3],
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("%0d results checked, %0d refused on full table, %0d without a match",
                 results_checked, full_refusals, unmatched);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
